// ===== design/wrm_pkg.sv =====
// Shared types and constants for the windowed RMS level meter.
// Used by wrm_root and windowed_rms_meter_unit; depends on nothing else.
`default_nettype none

package wrm_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int LEN_W    = 16;
    localparam int SUM_W    = 47;
    localparam int WIN_W    = 32;
    localparam int LEVEL_W  = 16;
    localparam int MAG_W    = 17;
    localparam int PROD_W   = 2 * MAG_W;

    // Serial step counts
    localparam int DIV_STEPS  = SUM_W + 2;          // dividend is sum * 4
    localparam int SQRT_STEPS = 17;                 // two radicand bits per step
    localparam int STEP_W     = 6;

    // Register reset value
    localparam logic [LEN_W-1:0] LEN_RESET = 16'd4000;

    // Input beat
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       stream_end;
    } wrm_in_t;

    // Output beat
    typedef struct packed {
        logic [WIN_W-1:0]   window_number;
        logic [LEVEL_W-1:0] rms_level;
    } wrm_out_t;

    // Request from the accumulator to the root unit
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] sum;
        logic [LEN_W-1:0] count;
    } wrm_root_req_t;

    // Status back from the root unit
    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] level;
    } wrm_root_stat_t;

endpackage

`default_nettype wire

// ===== design/windowed_rms_meter_unit.sv =====
// Top level of the windowed RMS level meter: serial squarer, window
// accumulator and output register. Depends on wrm_pkg and wrm_root.
//
// Usage:
//   in_*   : one beat per audio sample (signed sample, stream_end flag),
//            taken when in_valid is high and in_stall is low.
//   out_*  : one beat per reported window (window number, rounded RMS),
//            taken when out_valid is high and out_stall is low.
//   cfg_*  : writes window_length; cfg_ready is always high. Write only
//            while the block is idle.
// Sequence: each sample runs through 17 shift-add steps of the serial
//   squarer, one accumulate and one return to idle. A sample that closes a
//   window then passes through the root unit (49 division digits,
//   17 root digits, handover) before the result lands in the output register.
// Reset clears the sum, the count, the window number and out_valid; the
//   window length returns to 4000.
// A stalled result holds in the output register while the next sample is
//   taken; a further result waits in the block until the register drains.
`default_nettype none

module windowed_rms_meter_unit (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire wrm_pkg::wrm_in_t       in_data,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output wrm_pkg::wrm_out_t           out_data,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [15:0]            cfg_data
);
    import wrm_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SQUARE = 3'd1;
    localparam logic [2:0] ST_UPDATE = 3'd2;
    localparam logic [2:0] ST_ROOT   = 3'd3;
    localparam logic [2:0] ST_HOLD   = 3'd4;

    localparam int BIT_W = 5;

    logic [2:0]         state_reg, state_next;
    logic [MAG_W-1:0]   mag_reg, mag_next;
    logic [PROD_W-1:0]  acc_reg, acc_next;
    logic [BIT_W-1:0]   bit_reg, bit_next;
    logic               last_reg, last_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [LEN_W-1:0]   count_reg, count_next;
    logic [WIN_W-1:0]   wcount_reg, wcount_next;
    logic [WIN_W-1:0]   pend_reg, pend_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    wrm_out_t           out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic [LEN_W-1:0]   raw;
    logic [MAG_W-1:0]   in_mag;
    logic [MAG_W:0]     part_sum;
    logic [SUM_W-1:0]   new_sum;
    logic [LEN_W-1:0]   new_count;
    logic [LEN_W-1:0]   eff_len;
    logic               close_full;
    logic               close_short;
    logic               emit;
    logic               out_free;

    wrm_root_req_t      root_req;
    wrm_root_stat_t     root_stat;

    // Magnitude of the incoming sample, 0 to 32768
    assign raw    = in_data.sample;
    assign in_mag = raw[LEN_W-1] ? (MAG_W'(17'h10000) - {1'b0, raw}) : {1'b0, raw};

    // Shift-add step of the squarer
    assign part_sum = {1'b0, acc_reg[PROD_W-1:MAG_W]}
                    + (acc_reg[0] ? {1'b0, mag_reg} : '0);

    // Window accumulate and close decision
    assign new_sum     = sum_reg + SUM_W'(acc_reg);
    assign new_count   = count_reg + 1'b1;
    assign eff_len     = (len_reg == '0) ? LEN_W'(1) : len_reg;
    assign close_full  = new_count >= eff_len;
    assign close_short = last_reg && ({new_count, 1'b0} >= {1'b0, eff_len});
    assign emit        = close_full || close_short;

    assign out_free = !out_valid_reg || !out_stall;

    assign root_req.start = (state_reg == ST_UPDATE) && emit;
    assign root_req.sum   = new_sum;
    assign root_req.count = new_count;

    wrm_root u_root (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (root_req),
        .stat  (root_stat)
    );

    // Sequence squaring, accumulation and root handover
    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        acc_next       = acc_reg;
        bit_next       = bit_reg;
        last_next      = last_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        wcount_next    = wcount_reg;
        pend_next      = pend_reg;
        len_next       = len_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        // Drain the output register
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // Take a register write
        if (cfg_valid)
        begin
            len_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SQUARE;
                    mag_next   = in_mag;
                    acc_next   = {{MAG_W{1'b0}}, in_mag};
                    bit_next   = BIT_W'(MAG_W - 1);
                    last_next  = in_data.stream_end;
                end
            end
            ST_SQUARE:
            begin
                acc_next = {part_sum, acc_reg[MAG_W-1:1]};
                if (bit_reg == '0)
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    bit_next = bit_reg - 1'b1;
                end
            end
            ST_UPDATE:
            begin
                sum_next   = new_sum;
                count_next = new_count;
                if (emit)
                begin
                    // Root unit has latched the window; clear for the next one
                    state_next  = ST_ROOT;
                    pend_next   = wcount_reg;
                    sum_next    = '0;
                    count_next  = '0;
                    wcount_next = wcount_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
                if (last_reg)
                begin
                    sum_next    = '0;
                    count_next  = '0;
                    wcount_next = '0;
                end
            end
            ST_ROOT:
            begin
                if (root_stat.done)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next             = ST_IDLE;
                    out_next.window_number = pend_reg;
                    out_next.rms_level     = root_stat.level;
                    out_valid_next         = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            count_reg     <= '0;
            wcount_reg    <= '0;
            len_reg       <= LEN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            wcount_reg    <= wcount_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        acc_reg  <= acc_next;
        bit_reg  <= bit_next;
        last_reg <= last_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign in_stall  = state_reg != ST_IDLE;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

// ===== design/wrm_root.sv =====
// Bit-serial rounded RMS unit: restoring division of 4*sum by the count,
// then a two-bits-per-step integer square root. Depends on wrm_pkg.
`default_nettype none

module wrm_root (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire wrm_pkg::wrm_root_req_t req,
    output wrm_pkg::wrm_root_stat_t     stat
);
    import wrm_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_DIV  = 2'd1;
    localparam logic [1:0] PH_SQRT = 2'd2;

    localparam int DVD_W  = DIV_STEPS;
    localparam int QUO_W  = 33;
    localparam int RAD_W  = 2 * SQRT_STEPS;
    localparam int ROOT_W = SQRT_STEPS;
    localparam int SREM_W = ROOT_W + 1;

    logic [1:0]          phase_reg, phase_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [DVD_W-1:0]    dvd_reg, dvd_next;
    logic [LEN_W-1:0]    rem_reg, rem_next;
    logic [LEN_W-1:0]    divisor_reg, divisor_next;
    logic [RAD_W-1:0]    rad_reg, rad_next;
    logic [SREM_W-1:0]   srem_reg, srem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [LEVEL_W-1:0]  level_reg, level_next;
    logic                done_reg, done_next;

    // Division step signals
    logic [LEN_W:0]      div_sh;
    logic                div_ge;
    logic [LEN_W:0]      div_diff;
    logic [DVD_W-1:0]    dvd_step;

    // Root step signals
    logic [SREM_W+1:0]   sq_sh;
    logic [SREM_W+1:0]   sq_trial;
    logic                sq_ge;
    logic [SREM_W+1:0]   sq_diff;
    logic [ROOT_W-1:0]   root_step;
    logic [ROOT_W:0]     round_sum;

    // One restoring-division digit
    assign div_sh   = {rem_reg, dvd_reg[DVD_W-1]};
    assign div_ge   = div_sh >= {1'b0, divisor_reg};
    assign div_diff = div_sh - {1'b0, divisor_reg};
    assign dvd_step = {dvd_reg[DVD_W-2:0], div_ge};

    // One square-root digit
    assign sq_sh     = {srem_reg, rad_reg[RAD_W-1 -: 2]};
    assign sq_trial  = {1'b0, root_reg, 2'b01};
    assign sq_ge     = sq_sh >= sq_trial;
    assign sq_diff   = sq_sh - sq_trial;
    assign root_step = {root_reg[ROOT_W-2:0], sq_ge};
    // Round half up: r = (isqrt + 1) / 2
    assign round_sum = {1'b0, root_step} + {{ROOT_W{1'b0}}, 1'b1};

    // Sequence the division then the root
    always_comb
    begin
        phase_next   = phase_reg;
        step_next    = step_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        rad_next     = rad_reg;
        srem_next    = srem_reg;
        root_next    = root_reg;
        level_next   = level_reg;
        done_next    = 1'b0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (req.start)
                begin
                    phase_next   = PH_DIV;
                    step_next    = STEP_W'(DIV_STEPS - 1);
                    dvd_next     = {req.sum, 2'b00};
                    rem_next     = '0;
                    divisor_next = req.count;
                end
            end
            PH_DIV:
            begin
                dvd_next = dvd_step;
                rem_next = div_ge ? div_diff[LEN_W-1:0] : div_sh[LEN_W-1:0];
                if (step_reg == '0)
                begin
                    // Quotient is at most 2^32: hand its low bits to the root
                    phase_next = PH_SQRT;
                    step_next  = STEP_W'(SQRT_STEPS - 1);
                    rad_next   = RAD_W'(dvd_step[QUO_W-1:0]);
                    srem_next  = '0;
                    root_next  = '0;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            PH_SQRT:
            begin
                rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
                srem_next = sq_ge ? sq_diff[SREM_W-1:0] : sq_sh[SREM_W-1:0];
                root_next = root_step;
                if (step_reg == '0)
                begin
                    phase_next = PH_IDLE;
                    level_next = round_sum[LEVEL_W:1];
                    done_next  = 1'b1;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        step_reg    <= step_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        rad_reg     <= rad_next;
        srem_reg    <= srem_next;
        root_reg    <= root_next;
        level_reg   <= level_next;
    end

    assign stat.done  = done_reg;
    assign stat.level = level_reg;

endmodule

`default_nettype wire
